// File: rtl/rdbe_pkg.sv
package rdbe_pkg;

    // default sizing of the block
    localparam int MAX_SOURCE_DIM_DEF = 1024;
    localparam int DECIMATION_DEF     = 4;
    localparam int MAX_OUTPUT_DIM_DEF = 256;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'd1;

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // item payload widths
    localparam int PIX_W  = 16;
    localparam int BYTE_W = 8;

    // BMP header layout values
    localparam int HDR_BYTES      = 54;
    localparam int INFO_BYTES     = 40;
    localparam int BITS_PER_PIXEL = 24;
    localparam int PLANES         = 1;
    localparam logic [BYTE_W-1:0] MAGIC_B = 8'h42;
    localparam logic [BYTE_W-1:0] MAGIC_M = 8'h4d;

    // cycles the derived size pipeline needs after a register write
    localparam int SETTLE_CYCLES = 4;
    localparam int SETTLE_W      = 2;

    // controller to datapath
    typedef struct packed {
        logic load;   // store/advance for an accepted load item
        logic form;   // build the fetched byte into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } t_sts;

    // channel widening tables, rounded to nearest
    typedef logic [BYTE_W-1:0] t_lut5 [32];
    typedef logic [BYTE_W-1:0] t_lut6 [64];

    function automatic t_lut5 f_lut5();
        t_lut5 t;
        for (int i = 0; i < 32; i++) begin
            t[i] = BYTE_W'((i * 255 + 15) / 31);
        end
        return t;
    endfunction

    function automatic t_lut6 f_lut6();
        t_lut6 t;
        for (int i = 0; i < 64; i++) begin
            t[i] = BYTE_W'((i * 255 + 31) / 63);
        end
        return t;
    endfunction

    localparam t_lut5 WIDEN5 = f_lut5();
    localparam t_lut6 WIDEN6 = f_lut6();

endpackage

// File: rtl/rdbe_ctrl.sv
module rdbe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_in_valid,
    input  logic          i_req_type,
    input  logic          i_out_ready,
    input  rdbe_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output rdbe_pkg::t_cmd o_cmd
);
    import rdbe_pkg::*;

    typedef enum logic [2:0] {
        ST_SETTLE = 3'b001,
        ST_IDLE   = 3'b010,
        ST_FORM   = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [SETTLE_W-1:0] r_cnt, n_cnt;
    logic                accept;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = (r_state == ST_IDLE);
        accept     = i_in_valid && o_in_ready;
        o_cmd      = '0;
        case (r_state)
            ST_SETTLE: begin
                if (r_cnt == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_FETCH) begin
                        n_state = ST_FORM;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_FORM: begin
                // wait for a free output register
                if (!i_sts.out_full || i_out_ready) begin
                    o_cmd.form = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_SETTLE;
                n_cnt   = SETTLE_W'(SETTLE_CYCLES - 1);
            end
        endcase
        // a register write restarts the size pipeline
        if (i_cfg_we) begin
            n_state = ST_SETTLE;
            n_cnt   = SETTLE_W'(SETTLE_CYCLES - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SETTLE;
            r_cnt   <= SETTLE_W'(SETTLE_CYCLES - 1);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // no item taken while derived sizes settle
    a_settle_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_in_ready)
        else $error("item taken right after register write");

    // a fetch holds off further items until its byte is formed
    a_fetch_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == REQ_FETCH && !i_cfg_we) |=> (!o_in_ready && !o_cmd.load))
        else $error("item taken while fetch pending");

endmodule

// File: rtl/rdbe_datapath.sv
module rdbe_datapath #(
    parameter int MAX_SOURCE_DIM = rdbe_pkg::MAX_SOURCE_DIM_DEF,
    parameter int DECIMATION     = rdbe_pkg::DECIMATION_DEF,
    parameter int MAX_OUTPUT_DIM = rdbe_pkg::MAX_OUTPUT_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rdbe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rdbe_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [rdbe_pkg::PIX_W-1:0]     i_pixel_value,
    input  logic                           i_out_ready,
    input  rdbe_pkg::t_cmd                 i_cmd,
    output rdbe_pkg::t_sts                 o_sts,
    output logic                           o_out_valid,
    output logic [rdbe_pkg::BYTE_W-1:0]    o_file_byte,
    output logic                           o_last_byte,
    output logic                           o_status
);
    import rdbe_pkg::*;

    localparam int PH_W       = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int LC_W       = $clog2(MAX_SOURCE_DIM);
    localparam int CMP_W      = (LC_W + 1 > CFG_W) ? LC_W + 1 : CFG_W;
    localparam int Y_W        = (MAX_OUTPUT_DIM > 1) ? $clog2(MAX_OUTPUT_DIM) : 1;
    localparam int XF_W       = $clog2(MAX_OUTPUT_DIM + 1);
    localparam int XC_W       = (XF_W > CFG_W) ? XF_W : CFG_W;
    localparam int DEPTH      = MAX_OUTPUT_DIM * MAX_OUTPUT_DIM;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAX_STRIDE = ((3 * MAX_OUTPUT_DIM + 3) / 4) * 4;
    localparam int CB_W       = $clog2(MAX_STRIDE);
    localparam int STRIDE_W   = CFG_W + 2;
    localparam int CBC_W      = ((CB_W > STRIDE_W) ? CB_W : STRIDE_W) + 1;
    localparam int POS_W      = $clog2(HDR_BYTES + MAX_STRIDE * MAX_OUTPUT_DIM);
    // division by the decimation factor as multiply by reciprocal
    localparam int DIV_SH     = CFG_W + $clog2(DECIMATION);
    localparam int DIV_M      = ((2 ** DIV_SH) + DECIMATION - 1) / DECIMATION;
    localparam int PROD_W     = CFG_W + DIV_SH + 1;

    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    function automatic logic [CFG_W-1:0] f_div(input logic [CFG_W-1:0] v);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(v) * PROD_W'(DIV_M);
        return CFG_W'(prod >> DIV_SH);
    endfunction

    function automatic logic [BYTE_W-1:0] f_le(input logic [31:0] v, input logic [1:0] k);
        return v[8 * k +: 8];
    endfunction

    // configuration registers
    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;

    // derived size pipeline
    logic [CFG_W-1:0]    r_w, r_h, r_h_m1;
    logic                r_src_ok, r_ok;
    logic [STRIDE_W-1:0] r_stride, stride_raw;
    logic [POS_W-1:0]    r_pix, r_total, r_last_pos;

    // load position
    logic [LC_W-1:0] r_lc, r_lx, r_lr, r_ly, n_lc, n_lx, n_lr, n_ly;
    logic [PH_W-1:0] r_lph, r_rph, n_lph, n_rph;
    logic            store_hit;
    logic [ADDR_W-1:0] wr_addr;

    // fetch position
    logic [POS_W-1:0] r_pos, n_pos;
    logic [Y_W-1:0]   r_ri, n_ri;
    logic [CB_W-1:0]  r_cb, n_cb;
    logic [1:0]       r_ch, n_ch;
    logic [XF_W-1:0]  r_fx, n_fx;
    logic [CFG_W-1:0] fy;
    logic [ADDR_W-1:0] rd_addr;

    // frame store
    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    // output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_byte, n_byte, hdr_byte, pix_byte;
    logic              r_last, n_last, r_status, n_status;
    logic [5:0]        hp;
    logic              in_hdr, pix_on, at_last, row_end;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= '0;
            r_cfg_h <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_SRC_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end
            if (i_cfg_index == REG_SRC_HEIGHT) begin
                r_cfg_h <= i_cfg_data;
            end
        end
    end

    // size pipeline: output dims, then stride, then pixel bytes, then file size
    assign stride_raw = STRIDE_W'(r_w) * STRIDE_W'(3) + STRIDE_W'(3);
    always_ff @(posedge i_clk) begin
        r_w        <= f_div(r_cfg_w);
        r_h        <= f_div(r_cfg_h);
        r_src_ok   <= (CMP_W'(r_cfg_w) <= CMP_W'(MAX_SOURCE_DIM))
                   && (CMP_W'(r_cfg_h) <= CMP_W'(MAX_SOURCE_DIM));
        r_ok       <= r_src_ok && (r_w != '0) && (r_h != '0)
                   && (XC_W'(r_w) <= XC_W'(MAX_OUTPUT_DIM))
                   && (XC_W'(r_h) <= XC_W'(MAX_OUTPUT_DIM));
        r_stride   <= {stride_raw[STRIDE_W-1:2], 2'b00};
        r_h_m1     <= r_h - 1'b1;
        r_pix      <= POS_W'(r_stride) * POS_W'(r_h);
        r_total    <= r_pix + POS_W'(HDR_BYTES);
        r_last_pos <= r_pix + POS_W'(HDR_BYTES - 1);
    end

    // load side: keep one pixel in each decimation block
    assign store_hit = r_ok && (r_lph == '0) && (r_rph == '0)
                    && (CMP_W'(r_lx) < CMP_W'(r_w)) && (CMP_W'(r_ly) < CMP_W'(r_h));
    assign wr_addr   = ADDR_W'(Y_W'(r_ly)) * ADDR_W'(MAX_OUTPUT_DIM) + ADDR_W'(r_lx);

    always_comb begin
        n_lc  = r_lc;
        n_lx  = r_lx;
        n_lph = r_lph;
        n_lr  = r_lr;
        n_ly  = r_ly;
        n_rph = r_rph;
        if (i_cmd.load && r_ok) begin
            if (CMP_W'(r_lc) + 1'b1 >= CMP_W'(r_cfg_w)) begin
                n_lc  = '0;
                n_lx  = '0;
                n_lph = '0;
                if (CMP_W'(r_lr) + 1'b1 >= CMP_W'(r_cfg_h)) begin
                    n_lr  = '0;
                    n_ly  = '0;
                    n_rph = '0;
                end else begin
                    n_lr = r_lr + 1'b1;
                    if (r_rph == PH_W'(DECIMATION - 1)) begin
                        n_rph = '0;
                        n_ly  = r_ly + 1'b1;
                    end else begin
                        n_rph = r_rph + 1'b1;
                    end
                end
            end else begin
                n_lc = r_lc + 1'b1;
                if (r_lph == PH_W'(DECIMATION - 1)) begin
                    n_lph = '0;
                    n_lx  = r_lx + 1'b1;
                end else begin
                    n_lph = r_lph + 1'b1;
                end
            end
        end
    end

    // frame store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && store_hit) begin
            mem[wr_addr] <= i_pixel_value;
        end
        r_rdata <= mem[rd_addr];
    end

    // fetch side: rows bottom-up
    assign fy      = r_h_m1 - CFG_W'(r_ri);
    assign rd_addr = ADDR_W'(Y_W'(fy)) * ADDR_W'(MAX_OUTPUT_DIM) + ADDR_W'(r_fx);
    assign hp      = r_pos[5:0];
    assign in_hdr  = (r_pos < POS_W'(HDR_BYTES));
    assign pix_on  = (XC_W'(r_fx) < XC_W'(r_w));
    assign at_last = (r_pos == r_last_pos);
    assign row_end = (CBC_W'(r_cb) + 1'b1 == CBC_W'(r_stride));

    // header bytes
    always_comb begin
        hdr_byte = '0;
        if (hp == 6'd0) begin
            hdr_byte = MAGIC_B;
        end else if (hp == 6'd1) begin
            hdr_byte = MAGIC_M;
        end else if (hp >= 6'd2 && hp < 6'd6) begin
            hdr_byte = f_le(32'(r_total), 2'(hp - 6'd2));
        end else if (hp >= 6'd10 && hp < 6'd14) begin
            hdr_byte = f_le(32'(HDR_BYTES), 2'(hp - 6'd10));
        end else if (hp >= 6'd14 && hp < 6'd18) begin
            hdr_byte = f_le(32'(INFO_BYTES), 2'(hp - 6'd14));
        end else if (hp >= 6'd18 && hp < 6'd22) begin
            hdr_byte = f_le(32'(r_w), 2'(hp - 6'd18));
        end else if (hp >= 6'd22 && hp < 6'd26) begin
            hdr_byte = f_le(32'(r_h), 2'(hp - 6'd22));
        end else if (hp >= 6'd26 && hp < 6'd28) begin
            hdr_byte = f_le(32'(PLANES), 2'(hp - 6'd26));
        end else if (hp >= 6'd28 && hp < 6'd30) begin
            hdr_byte = f_le(32'(BITS_PER_PIXEL), 2'(hp - 6'd28));
        end else if (hp >= 6'd34 && hp < 6'd38) begin
            hdr_byte = f_le(32'(r_pix), 2'(hp - 6'd34));
        end
    end

    // pixel bytes in B,G,R order
    always_comb begin
        case (r_ch)
            CH_BLUE:  pix_byte = WIDEN5[r_rdata[4:0]];
            CH_GREEN: pix_byte = WIDEN6[r_rdata[10:5]];
            CH_RED:   pix_byte = WIDEN5[r_rdata[15:11]];
            default:  pix_byte = '0;
        endcase
    end

    // byte result and fetch advance
    always_comb begin
        n_byte   = r_byte;
        n_last   = r_last;
        n_status = r_status;
        n_pos    = r_pos;
        n_ri     = r_ri;
        n_cb     = r_cb;
        n_ch     = r_ch;
        n_fx     = r_fx;
        if (i_cmd.form) begin
            if (!r_ok) begin
                n_byte   = '0;
                n_last   = 1'b1;
                n_status = 1'b1;
                n_pos    = '0;
                n_ri     = '0;
                n_cb     = '0;
                n_ch     = CH_BLUE;
                n_fx     = '0;
            end else begin
                n_byte   = in_hdr ? hdr_byte : (pix_on ? pix_byte : '0);
                n_last   = at_last;
                n_status = 1'b0;
                if (at_last) begin
                    n_pos = '0;
                    n_ri  = '0;
                    n_cb  = '0;
                    n_ch  = CH_BLUE;
                    n_fx  = '0;
                end else begin
                    n_pos = r_pos + 1'b1;
                    if (!in_hdr) begin
                        if (row_end) begin
                            n_cb = '0;
                            n_ch = CH_BLUE;
                            n_fx = '0;
                            n_ri = r_ri + 1'b1;
                        end else begin
                            n_cb = r_cb + 1'b1;
                            if (r_ch == CH_RED) begin
                                n_ch = CH_BLUE;
                                n_fx = r_fx + 1'b1;
                            end else begin
                                n_ch = r_ch + 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    // position counters, cleared by any register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_lc  <= '0;
            r_lx  <= '0;
            r_lph <= '0;
            r_lr  <= '0;
            r_ly  <= '0;
            r_rph <= '0;
            r_pos <= '0;
            r_ri  <= '0;
            r_cb  <= '0;
            r_ch  <= CH_BLUE;
            r_fx  <= '0;
        end else begin
            r_lc  <= n_lc;
            r_lx  <= n_lx;
            r_lph <= n_lph;
            r_lr  <= n_lr;
            r_ly  <= n_ly;
            r_rph <= n_rph;
            r_pos <= n_pos;
            r_ri  <= n_ri;
            r_cb  <= n_cb;
            r_ch  <= n_ch;
            r_fx  <= n_fx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.form) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        r_byte   <= n_byte;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign o_sts.out_full = r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_file_byte    = r_byte;
    assign o_last_byte    = r_last;
    assign o_status       = r_status;

    // a result appears only from a form command
    a_valid_from_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.form))
        else $error("result item without form command");

    // an unavailable answer always ends the file
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status) |-> r_last)
        else $error("unavailable answer without last flag");

    // after the final byte the next fetch starts a new file
    a_wrap_to_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.form && r_ok && at_last && !i_cfg_we) |=> (r_pos == '0 && r_ri == '0))
        else $error("fetch position not back at start of file");

endmodule

// File: rtl/rgb565_decimating_bmp_encoder.sv
// RGB565 framebuffer to 24-bit BMP encoder with decimation. Load items (req_type 0) are
// taken one per cycle while the input side is ready; the pixel at every DECIMATION-th column
// of every DECIMATION-th row inside the output size goes into a frame store of MAX_OUTPUT_DIM x
// MAX_OUTPUT_DIM 16-bit words with one write port and one registered read port, which is not
// cleared at reset: load a whole frame before fetching. For a fetch item (req_type 1) the frame
// store read is registered at acceptance and the byte is formed into the output register once
// that register is free or its byte is being taken. The output register lets the next item be
// accepted while a byte waits to be taken; a further fetch then holds the input side until that
// byte is taken. After reset and after every register write the input side stays not-ready
// while the output size, row stride and file size are recomputed; each write also restarts
// both load and fetch positions at the start of the frame and of the file. An invalid size
// answers each fetch with byte 0, last_byte 1 and status 1, and ignores loads.
module rgb565_decimating_bmp_encoder #(
    parameter int MAX_SOURCE_DIM = rdbe_pkg::MAX_SOURCE_DIM_DEF,
    parameter int DECIMATION     = rdbe_pkg::DECIMATION_DEF,
    parameter int MAX_OUTPUT_DIM = rdbe_pkg::MAX_OUTPUT_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [rdbe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rdbe_pkg::CFG_W-1:0]     i_cfg_data,
    // request items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [rdbe_pkg::PIX_W-1:0]     i_pixel_value,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rdbe_pkg::BYTE_W-1:0]    o_file_byte,
    output logic                           o_last_byte,
    output logic                           o_status
);
    import rdbe_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing
    rdbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    // store, counters and byte formation
    rdbe_datapath #(
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
        .DECIMATION     (DECIMATION),
        .MAX_OUTPUT_DIM (MAX_OUTPUT_DIM)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_value (i_pixel_value),
        .i_out_ready   (i_out_ready),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_file_byte   (o_file_byte),
        .o_last_byte   (o_last_byte),
        .o_status      (o_status)
    );

endmodule

// File: dv/rgb565_decimating_bmp_encoder_test.sv
module rgb565_decimating_bmp_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    // block geometry as the test sees it
    localparam int SRC_LIMIT    = 1024;
    localparam int DECIM        = 4;
    localparam int OUT_LIMIT    = 256;
    localparam int FILE_HDR_LEN = 54;
    localparam int DIB_LEN      = 40;
    localparam int PIXEL_BITS   = 24;

    // run control
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 8;
    localparam int MAX_PRINTED      = 40;

    typedef struct packed {
        logic [rdbe_pkg::BYTE_W-1:0] file_byte;
        logic                        last_byte;
        logic                        status;
    } bmp_byte_t;

    // predicts the BMP byte stream and checks what the block returns
    class bmp_byte_scoreboard;
        int unsigned src_width, src_height;
        int unsigned src_col, src_row, byte_pos;
        bit [15:0]   kept_pixels [int];
        bmp_byte_t   pending_bytes [$];
        int unsigned mismatches, bytes_checked, pixels_kept, files_read, unavailable_answers;

        function void set_register(logic [rdbe_pkg::CFG_IDX_W-1:0] index,
                                   logic [rdbe_pkg::CFG_W-1:0] value);
            case (index)
                rdbe_pkg::REG_SRC_WIDTH:  src_width = value;
                rdbe_pkg::REG_SRC_HEIGHT: src_height = value;
                default: return;
            endcase
            src_col  = 0;
            src_row  = 0;
            byte_pos = 0;
        endfunction

        // output size, row stride and file length; 0 when the size cannot be encoded
        function bit geometry(output int unsigned ow, output int unsigned oh,
                              output int unsigned stride, output int unsigned file_len);
            ow       = src_width / DECIM;
            oh       = src_height / DECIM;
            stride   = ((ow * PIXEL_BITS + 31) / 32) * 4;
            file_len = FILE_HDR_LEN + stride * oh;
            return ow > 0 && oh > 0 && ow <= OUT_LIMIT && oh <= OUT_LIMIT
                && src_width <= SRC_LIMIT && src_height <= SRC_LIMIT;
        endfunction

        // store slot behind a file byte, or -1 for header and padding bytes
        function int pixel_slot(int unsigned pos, int unsigned ow, int unsigned oh,
                                int unsigned stride, output int unsigned channel);
            int unsigned offset, line, col_byte;
            channel = 0;
            if (pos < FILE_HDR_LEN) return -1;
            offset   = pos - FILE_HDR_LEN;
            line     = offset / stride;
            col_byte = offset % stride;
            if (col_byte >= ow * 3 || line >= oh) return -1;
            channel = col_byte % 3;
            // rows go out bottom-up
            return (oh - 1 - line) * OUT_LIMIT + col_byte / 3;
        endfunction

        // little-endian header fields
        function bit [7:0] header_field(int unsigned pos, int unsigned ow, int unsigned oh,
                                        int unsigned image_len, int unsigned file_len);
            int unsigned word, base;
            if (pos == 0) return 8'h42;
            if (pos == 1) return 8'h4d;
            word = 0;
            base = pos;
            if (pos >= 2 && pos < 6) begin
                word = file_len;
                base = 2;
            end else if (pos >= 10 && pos < 14) begin
                word = FILE_HDR_LEN;
                base = 10;
            end else if (pos >= 14 && pos < 18) begin
                word = DIB_LEN;
                base = 14;
            end else if (pos >= 18 && pos < 22) begin
                word = ow;
                base = 18;
            end else if (pos >= 22 && pos < 26) begin
                word = oh;
                base = 22;
            end else if (pos >= 26 && pos < 28) begin
                word = 1;
                base = 26;
            end else if (pos >= 28 && pos < 30) begin
                word = PIXEL_BITS;
                base = 28;
            end else if (pos >= 34 && pos < 38) begin
                word = image_len;
                base = 34;
            end
            return 8'(word >> (8 * (pos - base)));
        endfunction

        // channel widening to 8 bits, rounded to nearest
        function bit [7:0] widen(int unsigned v, int unsigned max_code);
            return 8'((v * 255 + max_code / 2) / max_code);
        endfunction

        function int unsigned fetch_pos(int unsigned file_len);
            return (byte_pos >= file_len) ? 0 : byte_pos;
        endfunction

        // true when the next fetch would read a store entry never loaded
        function bit fetch_hits_unwritten();
            int unsigned ow, oh, stride, file_len, channel;
            int slot;
            if (!geometry(ow, oh, stride, file_len)) return 0;
            slot = pixel_slot(fetch_pos(file_len), ow, oh, stride, channel);
            return slot >= 0 && !kept_pixels.exists(slot);
        endfunction

        // accepted input item: update state, queue the byte a fetch returns
        function void note_request(logic req, logic [15:0] pixel);
            int unsigned ow, oh, stride, file_len, pos, channel;
            int slot;
            bit [15:0] word;
            bmp_byte_t want;
            bit ok;
            ok = geometry(ow, oh, stride, file_len);
            if (req == rdbe_pkg::REQ_LOAD) begin
                if (!ok) return;
                if (src_col % DECIM == 0 && src_row % DECIM == 0
                    && src_col / DECIM < ow && src_row / DECIM < oh) begin
                    kept_pixels[(src_row / DECIM) * OUT_LIMIT + src_col / DECIM] = pixel;
                    pixels_kept++;
                end
                src_col++;
                if (src_col >= src_width) begin
                    src_col = 0;
                    src_row++;
                    if (src_row >= src_height) src_row = 0;
                end
                return;
            end
            if (!ok) begin
                byte_pos = 0;
                want = '{file_byte: 8'h00, last_byte: 1'b1, status: 1'b1};
                pending_bytes.push_back(want);
                return;
            end
            pos  = fetch_pos(file_len);
            slot = pixel_slot(pos, ow, oh, stride, channel);
            want.status    = 1'b0;
            want.last_byte = (pos == file_len - 1);
            if (pos < FILE_HDR_LEN) begin
                want.file_byte = header_field(pos, ow, oh, stride * oh, file_len);
            end else if (slot < 0) begin
                want.file_byte = 8'h00;
            end else begin
                word = kept_pixels.exists(slot) ? kept_pixels[slot] : 16'h0000;
                // B, G, R order
                case (channel)
                    0:       want.file_byte = widen(word[4:0], 31);
                    1:       want.file_byte = widen(word[10:5], 63);
                    default: want.file_byte = widen(word[15:11], 31);
                endcase
            end
            byte_pos = want.last_byte ? 0 : (pos + 1) & 32'h3ffff;
            pending_bytes.push_back(want);
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_PRINTED) $display("MISMATCH %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // accepted result item against the oldest expectation
        task check_byte(logic [7:0] got_byte, logic got_last, logic got_status);
            bmp_byte_t want;
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("byte %02h last %b status %b with nothing expected",
                                          got_byte, got_last, got_status));
                return;
            end
            want = pending_bytes.pop_front();
            if (got_byte !== want.file_byte)
                report_mismatch($sformatf("file_byte %02h, expected %02h (byte %0d)",
                                          got_byte, want.file_byte, bytes_checked));
            if (got_last !== want.last_byte)
                report_mismatch($sformatf("last_byte %b, expected %b (byte %0d)",
                                          got_last, want.last_byte, bytes_checked));
            if (got_status !== want.status)
                report_mismatch($sformatf("status %b, expected %b (byte %0d)",
                                          got_status, want.status, bytes_checked));
            bytes_checked++;
            if (want.status) unavailable_answers++;
            else if (want.last_byte) files_read++;
        endtask
    endclass

    logic                           i_clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [rdbe_pkg::CFG_IDX_W-1:0] cfg_index = rdbe_pkg::REG_SRC_WIDTH;
    logic [rdbe_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           req_type = rdbe_pkg::REQ_LOAD;
    logic [rdbe_pkg::PIX_W-1:0]     pixel_value = '0;
    logic                           out_ready = 1'b0;
    logic                           o_in_ready, o_out_valid, o_last_byte, o_status;
    logic [rdbe_pkg::BYTE_W-1:0]    o_file_byte;

    bmp_byte_scoreboard screenshot = new;
    int unsigned cycles = 0;
    int unsigned size_settings = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    bit          calm = 1'b0;
    logic        hold_request = 1'b0;
    bit          hold_served = 1'b0;

    rgb565_decimating_bmp_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (req_type),
        .i_pixel_value (pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_file_byte   (o_file_byte),
        .o_last_byte   (o_last_byte),
        .o_status      (o_status)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes outstanding",
                     cycles, screenshot.pending_bytes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off when asked
    initial begin : sink_pacing
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                out_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                out_ready <= 1'b1;
            end else if (!calm && sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready)
            screenshot.check_byte(o_file_byte, o_last_byte, o_status);
    end

    // offer one item, wait for it to be taken, then predict it
    task automatic send_item(input logic req, input logic [15:0] pixel);
        int gap;
        if (!calm && src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        pixel_value <= pixel;
        do @(posedge i_clk); while (!o_in_ready);
        screenshot.note_request(req, pixel);
    endtask

    // program both size registers once the block has gone quiet
    task automatic set_size(input int unsigned width, input int unsigned height);
        in_valid <= 1'b0;
        while (screenshot.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= rdbe_pkg::REG_SRC_WIDTH;
        cfg_data  <= rdbe_pkg::CFG_W'(width);
        @(posedge i_clk);
        screenshot.set_register(rdbe_pkg::REG_SRC_WIDTH, rdbe_pkg::CFG_W'(width));
        cfg_index <= rdbe_pkg::REG_SRC_HEIGHT;
        cfg_data  <= rdbe_pkg::CFG_W'(height);
        @(posedge i_clk);
        screenshot.set_register(rdbe_pkg::REG_SRC_HEIGHT, rdbe_pkg::CFG_W'(height));
        cfg_we <= 1'b0;
        size_settings++;
    endtask

    // one whole source frame in raster order
    task automatic load_frame();
        int unsigned count;
        count = screenshot.src_width * screenshot.src_height;
        repeat (count) send_item(rdbe_pkg::REQ_LOAD, 16'($urandom));
    endtask

    // mixed loads and fetches; a fetch that would read an unloaded pixel becomes a load
    task automatic mixed_items(input int unsigned count, input int unsigned fetch_pct);
        repeat (count) begin
            if ($urandom_range(99) < fetch_pct && !screenshot.fetch_hits_unwritten())
                send_item(rdbe_pkg::REQ_FETCH, 16'($urandom));
            else
                send_item(rdbe_pkg::REQ_LOAD, 16'($urandom));
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        // size 0 x 0 after reset: fetches unavailable, loads ignored
        send_item(rdbe_pkg::REQ_FETCH, 16'hffff);
        send_item(rdbe_pkg::REQ_LOAD, 16'hffff);
        send_item(rdbe_pkg::REQ_FETCH, 16'h0000);

        // 9 x 4 source: two kept pixels, column 8 dropped; read the file and wrap
        set_size(9, 4);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 9; c++) begin
                if (r == 0 && c == 0)      send_item(rdbe_pkg::REQ_LOAD, 16'h0000);
                else if (r == 0 && c == 4) send_item(rdbe_pkg::REQ_LOAD, 16'hffff);
                else                       send_item(rdbe_pkg::REQ_LOAD, 16'($urandom));
            end
        end
        repeat (64) send_item(rdbe_pkg::REQ_FETCH, 16'($urandom));

        // invalid sizes: zero output, oversized source, oversized output
        set_size(3, 8);
        send_item(rdbe_pkg::REQ_FETCH, 16'h0000);
        send_item(rdbe_pkg::REQ_LOAD, 16'h1234);
        set_size(1028, 8);
        send_item(rdbe_pkg::REQ_FETCH, 16'h0000);
        set_size(8, 1025);
        send_item(rdbe_pkg::REQ_LOAD, 16'h4321);
        send_item(rdbe_pkg::REQ_FETCH, 16'hffff);
        set_size(2047, 2047);
        send_item(rdbe_pkg::REQ_FETCH, 16'h0000);

        // largest size: only the header can be read without a full frame
        src_idle_pct  = 8;
        sink_idle_pct = 5;
        set_size(1024, 1024);
        mixed_items(90, 75);

        // widest output, with a long hold-off on the result side while items keep coming
        src_idle_pct  = 0;
        set_size(1024, 4);
        hold_request <= 1'b1;
        mixed_items(320, 60);

        // tallest output
        src_idle_pct  = 20;
        sink_idle_pct = 10;
        set_size(4, 1024);
        mixed_items(80, 80);

        // random small frames, now and then an invalid size; last part without idling
        for (int k = 0; k < 6; k++) begin
            case ($urandom_range(2))
                0: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
                1: begin
                    src_idle_pct  = 10;
                    sink_idle_pct = 5;
                end
                default: begin
                    src_idle_pct  = 30;
                    sink_idle_pct = 20;
                end
            endcase
            if (k == 5) calm = 1'b1;
            if (k != 5 && $urandom_range(4) == 0) begin
                case ($urandom_range(2))
                    0:       set_size($urandom_range(0, 3), $urandom_range(0, 2047));
                    1:       set_size($urandom_range(1025, 2047), $urandom_range(4, 64));
                    default: set_size($urandom_range(4, 64), $urandom_range(1025, 2047));
                endcase
                mixed_items(12, 50);
            end else begin
                set_size($urandom_range(4, 15), $urandom_range(4, 12));
                load_frame();
                mixed_items(100, 80);
            end
        end

        // let the last bytes drain
        in_valid <= 1'b0;
        while (screenshot.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Checked %0d file bytes (%0d whole files, %0d unavailable answers)",
                 screenshot.bytes_checked, screenshot.files_read,
                 screenshot.unavailable_answers);
        $display("Kept %0d decimated pixels over %0d size settings, %0d mismatches",
                 screenshot.pixels_kept, size_settings, screenshot.mismatches);
        if (screenshot.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
